@@ hw/rtl/cvhp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cvhp_pkg;

  localparam int VOTE_BINS_DEF   = 256;
  localparam int COUNT_WIDTH_DEF = 20;

  localparam int WORD_W       = 32;
  localparam int VOTE_W       = 8;
  localparam int VOTE_LSB     = 8;
  localparam int CFG_W        = 20;
  localparam int CFG_IDX_W    = 8;
  localparam int EXP_W        = 8;
  localparam int DUST_W       = 63;
  localparam int DUST_CAP_EXP = 62;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_BUDGET = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] CYCLE_LENGTH_RST   = CFG_W'(1024);
  localparam logic [CFG_W-1:0] DISCARD_BUDGET_RST = CFG_W'(51);

  typedef struct packed {
    logic [VOTE_W-1:0] vote;
    logic              close;
  } vote_entry_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_WRITE,
    BK_SCAN,
    BK_TAIL,
    BK_EMIT
  } back_state_e;

endpackage

`default_nettype wire

@@ hw/rtl/cycle_vote_histogram_percentile.sv @@
// result: a beat that closes a cycle gives its result once its bin is written back, every bin
//   is scanned and cleared, and the result is registered for output; other beats give none
// flow: the read-modify-write of the histogram memory lets the back end take one beat at a time;
//   a 4-entry queue absorbs bursts, and each cycle close adds a scan over every bin
// reset: a clearing pass over every bin zeroes the histogram; no beats accepted meanwhile
`timescale 1ns / 1ps
`default_nettype none

module cycle_vote_histogram_percentile
  import cvhp_pkg::*;
#(
  parameter int VOTE_BINS   = VOTE_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [WORD_W-1:0]    version_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [EXP_W-1:0]          winning_exponent_o,
  output logic [DUST_W-1:0]         dust_value_o,
  output logic                      found_o
);

  logic             clearing;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  vote_entry_t      push_entry;
  vote_entry_t      head_entry;
  logic [CFG_W-1:0] discard_budget;

  cvhp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .version_word_i   (version_word_i),
    .clearing_i       (clearing),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_entry_o        (push_entry),
    .discard_budget_o (discard_budget)
  );

  cvhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  cvhp_back #(
    .VOTE_BINS   (VOTE_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_entry_i          (head_entry),
    .q_pop_o            (q_pop),
    .discard_budget_i   (discard_budget),
    .clearing_o         (clearing),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .winning_exponent_o (winning_exponent_o),
    .dust_value_o       (dust_value_o),
    .found_o            (found_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/cvhp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cvhp_front
  import cvhp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [WORD_W-1:0]    version_word_i,
  input  wire logic                 clearing_i,
  input  wire logic                 q_full_i,
  output logic                      q_push_o,
  output vote_entry_t               q_entry_o,
  output logic [CFG_W-1:0]          discard_budget_o
);

  logic [CFG_W-1:0] cycle_length_q, cycle_length_d;
  logic [CFG_W-1:0] discard_budget_q, discard_budget_d;
  logic [CFG_W-1:0] blocks_q, blocks_d;
  logic [CFG_W-1:0] blocks_inc;
  logic [CFG_W-1:0] limit;
  logic             close;
  logic             accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !clearing_i && !q_full_i;
  assign accept      = in_valid_i && in_ready_o;

  assign blocks_inc = blocks_q + CFG_W'(1);
  assign limit      = (cycle_length_q == '0) ? CFG_W'(1) : cycle_length_q;
  assign close      = (blocks_inc == '0) || (blocks_inc >= limit);

  always_comb begin
    cycle_length_d   = cycle_length_q;
    discard_budget_d = discard_budget_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_CYCLE_LENGTH) begin
        cycle_length_d = cfg_data_i;
      end else if (cfg_index_i == CFG_DISCARD_BUDGET) begin
        discard_budget_d = cfg_data_i;
      end
    end
    blocks_d = blocks_q;
    if (accept) begin
      blocks_d = close ? '0 : blocks_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_length_q   <= CYCLE_LENGTH_RST;
      discard_budget_q <= DISCARD_BUDGET_RST;
      blocks_q         <= '0;
    end else begin
      cycle_length_q   <= cycle_length_d;
      discard_budget_q <= discard_budget_d;
      blocks_q         <= blocks_d;
    end
  end

  assign q_push_o         = accept;
  assign q_entry_o.vote   = version_word_i[VOTE_LSB +: VOTE_W];
  assign q_entry_o.close  = close;
  assign discard_budget_o = discard_budget_q;

endmodule

`default_nettype wire

@@ hw/rtl/cvhp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cvhp_queue
  import cvhp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire vote_entry_t entry_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             valid_o,
  output vote_entry_t      entry_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  vote_entry_t         slots_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cvhp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cvhp_back
  import cvhp_pkg::*;
#(
  parameter int VOTE_BINS   = VOTE_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire vote_entry_t       q_entry_i,
  output logic                   q_pop_o,
  input  wire logic [CFG_W-1:0]  discard_budget_i,
  output logic                   clearing_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [EXP_W-1:0]       winning_exponent_o,
  output logic [DUST_W-1:0]      dust_value_o,
  output logic                   found_o
);

  localparam int BinW = $clog2(VOTE_BINS);
  localparam int SumW = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;

  logic [COUNT_WIDTH-1:0] mem [VOTE_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic [BinW-1:0]        rd_addr, wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   mem_we;

  back_state_e            state_q, state_d;
  logic [BinW-1:0]        idx_q, idx_d;
  logic [BinW-1:0]        pidx_q, pidx_d;
  logic                   scan_v_q, scan_v_d;
  logic [BinW-1:0]        bin_q, bin_d;
  logic                   close_q, close_d;
  logic [SumW-1:0]        taken_q, taken_d;
  logic                   found_q, found_d;
  logic [BinW-1:0]        exp_q, exp_d;
  logic                   out_valid_q, out_valid_d;
  logic [EXP_W-1:0]       out_exp_q, out_exp_d;
  logic [DUST_W-1:0]      out_dust_q, out_dust_d;
  logic                   out_found_q, out_found_d;

  logic [BinW-1:0]        vote_bin;
  logic [SumW-1:0]        sum;
  logic                   last_idx;

  assign vote_bin = (32'(q_entry_i.vote) >= VOTE_BINS) ? BinW'(VOTE_BINS - 1)
                                                       : BinW'(q_entry_i.vote);
  assign last_idx = (idx_q == BinW'(VOTE_BINS - 1));
  assign sum      = taken_q + SumW'(rd_data_q);

  // histogram memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    scan_v_d    = scan_v_q;
    bin_d       = bin_q;
    close_d     = close_q;
    taken_d     = taken_q;
    found_d     = found_q;
    exp_d       = exp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_exp_d   = out_exp_q;
    out_dust_d  = out_dust_q;
    out_found_d = out_found_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    rd_addr     = idx_q;
    wr_addr     = idx_q;
    wr_data     = '0;

    // running sum over the bin read in the previous cycle
    if ((state_q == BK_SCAN || state_q == BK_TAIL) && scan_v_q && !found_q) begin
      if (sum > SumW'(discard_budget_i)) begin
        found_d = 1'b1;
        exp_d   = pidx_q;
      end else begin
        taken_d = sum;
      end
    end

    unique case (state_q)
      BK_CLEAR: begin
        mem_we = 1'b1;
        if (last_idx) begin
          idx_d   = '0;
          state_d = BK_IDLE;
        end else begin
          idx_d = idx_q + BinW'(1);
        end
      end
      BK_IDLE: begin
        rd_addr = vote_bin;
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          bin_d   = vote_bin;
          close_d = q_entry_i.close;
          state_d = BK_WRITE;
        end
      end
      BK_WRITE: begin
        mem_we  = 1'b1;
        wr_addr = bin_q;
        wr_data = (rd_data_q == '1) ? rd_data_q : rd_data_q + COUNT_WIDTH'(1);
        if (close_q) begin
          idx_d    = '0;
          scan_v_d = 1'b0;
          taken_d  = '0;
          found_d  = 1'b0;
          exp_d    = '0;
          state_d  = BK_SCAN;
        end else begin
          state_d = BK_IDLE;
        end
      end
      BK_SCAN: begin
        // read each bin and clear it behind the read
        mem_we   = 1'b1;
        pidx_d   = idx_q;
        scan_v_d = 1'b1;
        if (last_idx) begin
          idx_d   = '0;
          state_d = BK_TAIL;
        end else begin
          idx_d = idx_q + BinW'(1);
        end
      end
      BK_TAIL: begin
        scan_v_d = 1'b0;
        state_d  = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          out_exp_d   = EXP_W'(exp_q);
          if (!found_q) begin
            out_dust_d = '0;
          end else if (32'(exp_q) >= DUST_CAP_EXP) begin
            out_dust_d = DUST_W'(1) << DUST_CAP_EXP;
          end else begin
            out_dust_d = DUST_W'(1) << exp_q;
          end
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      idx_q       <= '0;
      scan_v_q    <= 1'b0;
      close_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      scan_v_q    <= scan_v_d;
      close_q     <= close_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q      <= pidx_d;
    bin_q       <= bin_d;
    taken_q     <= taken_d;
    exp_q       <= exp_d;
    out_exp_q   <= out_exp_d;
    out_dust_q  <= out_dust_d;
    out_found_q <= out_found_d;
  end

  assign clearing_o         = (state_q == BK_CLEAR);
  assign out_valid_o        = out_valid_q;
  assign winning_exponent_o = out_exp_q;
  assign dust_value_o       = out_dust_q;
  assign found_o            = out_found_q;

endmodule

`default_nettype wire
